FILE: rtl/coprocessor_dma_register_block_assert.svh
// Assertion macros shared by the checker files of the DMA register block.
// Depends on nothing; include by bare file name inside a module body.
`ifndef COPROCESSOR_DMA_REGISTER_BLOCK_ASSERT_SVH
`define COPROCESSOR_DMA_REGISTER_BLOCK_ASSERT_SVH

// Check a property on every rising edge, quiet while reset is asserted.
`define CDRB_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every rising edge, reset included.
`define CDRB_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/cdrb_pkg.sv
// Shared types and constants of the coprocessor DMA register block.
// Used by every module of the block; depends on nothing.
package cdrb_pkg;

    // Memory sizes in bytes
    localparam int unsigned LOCAL_BYTES = 8192;
    localparam int unsigned DRAM_BYTES  = 8388608;

    // Beat-aligned wrap masks
    localparam logic [12:0] LOCAL_MASK = 13'(LOCAL_BYTES - 8);
    localparam logic [23:0] DRAM_MASK  = 24'(DRAM_BYTES - 8);

    // Request kinds
    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;

    // Register indexes
    localparam logic [2:0] REG_LOCAL  = 3'd0;
    localparam logic [2:0] REG_DRAM   = 3'd1;
    localparam logic [2:0] REG_LEN    = 3'd2;
    localparam logic [2:0] REG_STATUS = 3'd3;
    localparam logic [2:0] REG_SEMA   = 3'd4;

    // Stream widths
    localparam int unsigned IN_TDATA_W  = 32;
    localparam int unsigned IN_TUSER_W  = 5;
    localparam int unsigned OUT_TDATA_W = 72;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [2:0]  reg_index;
        logic [31:0] write_data;
    } t_req;

    typedef struct packed {
        logic [31:0] read_data;
        logic        beat_valid;
        logic [9:0]  beat_local_index;
        logic [19:0] beat_dram_index;
        logic        dma_busy;
        logic        dma_done;
        logic        interrupt_line;
    } t_rsp;

    // Output stage control and status
    typedef struct packed {
        logic load;
        logic take;
    } t_obuf_ctl;

    typedef struct packed {
        logic valid;
        logic room;
    } t_obuf_sts;

endpackage

FILE: rtl/cdrb_core.sv
// Register file, status logic and DMA sequencer of the register block.
// Depends on cdrb_pkg; executes one request per cycle when i_fire is high.
module cdrb_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_fire,
    input  cdrb_pkg::t_req i_req,
    output cdrb_pkg::t_rsp o_rsp
);
    import cdrb_pkg::*;

    // Architectural state
    logic [12:0] r_local,  n_local;
    logic [23:0] r_dram,   n_dram;
    logic [31:0] r_len,    n_len;
    logic        r_halt,   n_halt;
    logic        r_broke,  n_broke;
    logic [8:0]  r_sig,    n_sig;
    logic        r_sema,   n_sema;
    logic        r_irq,    n_irq;
    logic [7:0]  r_rows,   n_rows;
    logic [9:0]  r_beats,  n_beats;
    logic        r_active, n_active;

    // Tick datapath
    logic        tick_go;
    logic        beat;
    logic [12:0] loc_step;
    logic [12:0] loc_skip;
    logic [9:0]  beats_dec;
    logic [31:0] rd;
    logic        done;

    // Beats in one row: byte length rounded up to 8
    function automatic logic [9:0] row_beats(input logic [11:0] len_bytes);
        logic [12:0] sum;
        sum = {1'b0, len_bytes} + 13'd7;
        return sum[12:3];
    endfunction

    // Datapath for a tick of the DMA engine
    always_comb begin
        tick_go   = r_active && !r_halt;
        beat      = tick_go && (r_beats != 10'd0);
        loc_step  = beat ? ((r_local & LOCAL_MASK) + 13'd8) & LOCAL_MASK : r_local;
        beats_dec = beat ? r_beats - 10'd1 : r_beats;
        loc_skip  = 13'(14'(loc_step) + 14'(r_len[31:20])) & LOCAL_MASK;
    end

    // Next state and result for the current request
    always_comb begin
        n_local  = r_local;
        n_dram   = r_dram;
        n_len    = r_len;
        n_halt   = r_halt;
        n_broke  = r_broke;
        n_sig    = r_sig;
        n_sema   = r_sema;
        n_irq    = r_irq;
        n_rows   = r_rows;
        n_beats  = r_beats;
        n_active = r_active;
        rd       = 32'd0;
        done     = 1'b0;

        case (i_req.opcode)
            OP_WRITE: begin
                case (i_req.reg_index)
                    REG_LOCAL: begin
                        if (!r_active) begin
                            n_local = i_req.write_data[12:0];
                        end
                    end
                    REG_DRAM: begin
                        if (!r_active) begin
                            n_dram = i_req.write_data[23:0];
                        end
                    end
                    REG_LEN: begin
                        if (!r_active) begin
                            n_len = i_req.write_data;
                            if (i_req.write_data != 32'd0) begin
                                n_active = 1'b1;
                                n_rows   = i_req.write_data[19:12];
                                n_beats  = row_beats(i_req.write_data[11:0]);
                            end
                        end
                    end
                    REG_STATUS: begin
                        // Clear then set: set wins
                        if (i_req.write_data[0]) n_halt = 1'b0;
                        if (i_req.write_data[1]) n_halt = 1'b1;
                        if (i_req.write_data[2]) n_broke = 1'b0;
                        if (i_req.write_data[3]) n_irq = 1'b0;
                        if (i_req.write_data[4]) n_irq = 1'b1;
                        for (int k = 0; k < 9; k++) begin
                            if (i_req.write_data[5 + 2 * k]) n_sig[k] = 1'b0;
                            if (i_req.write_data[6 + 2 * k]) n_sig[k] = 1'b1;
                        end
                    end
                    REG_SEMA: begin
                        n_sema = 1'b0;
                    end
                    default: begin
                    end
                endcase
            end
            OP_READ: begin
                case (i_req.reg_index)
                    REG_STATUS: begin
                        rd = {18'd0, r_sig, 3'd0, r_broke, r_halt};
                    end
                    REG_SEMA: begin
                        rd     = {31'd0, r_sema};
                        n_sema = 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
            OP_TICK: begin
                if (tick_go) begin
                    n_local = loc_step;
                    n_beats = beats_dec;
                    if (beat) begin
                        n_dram = ((r_dram & DRAM_MASK) + 24'd8) & DRAM_MASK;
                    end
                    // End of row: add the skip, then next row or finish
                    if (beats_dec == 10'd0) begin
                        n_local = loc_skip;
                        if (r_rows == 8'd0) begin
                            n_active = 1'b0;
                            n_len    = 32'd0;
                            done     = 1'b1;
                        end else begin
                            n_rows  = r_rows - 8'd1;
                            n_beats = row_beats(r_len[11:0]);
                        end
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // Result of the current request
    always_comb begin
        o_rsp.read_data        = rd;
        o_rsp.beat_valid       = (i_req.opcode == OP_TICK) && beat;
        o_rsp.beat_local_index = ((i_req.opcode == OP_TICK) && beat)
                                 ? 10'((r_local & LOCAL_MASK) >> 3) : 10'd0;
        o_rsp.beat_dram_index  = ((i_req.opcode == OP_TICK) && beat)
                                 ? 20'((r_dram & DRAM_MASK) >> 3) : 20'd0;
        o_rsp.dma_busy         = n_active;
        o_rsp.dma_done         = done;
        o_rsp.interrupt_line   = n_irq;
    end

    // Commit state on an executed request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_local  <= 13'd0;
            r_dram   <= 24'd0;
            r_len    <= 32'd0;
            r_halt   <= 1'b1;
            r_broke  <= 1'b0;
            r_sig    <= 9'd0;
            r_sema   <= 1'b0;
            r_irq    <= 1'b0;
            r_rows   <= 8'd0;
            r_beats  <= 10'd0;
            r_active <= 1'b0;
        end else if (i_fire) begin
            r_local  <= n_local;
            r_dram   <= n_dram;
            r_len    <= n_len;
            r_halt   <= n_halt;
            r_broke  <= n_broke;
            r_sig    <= n_sig;
            r_sema   <= n_sema;
            r_irq    <= n_irq;
            r_rows   <= n_rows;
            r_beats  <= n_beats;
            r_active <= n_active;
        end
    end

endmodule

FILE: rtl/cdrb_out_reg.sv
// Result register of the register block, holding one response under stall.
// Depends on cdrb_pkg.
module cdrb_out_reg (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  cdrb_pkg::t_obuf_ctl i_ctl,
    input  cdrb_pkg::t_rsp      i_rsp,
    output cdrb_pkg::t_obuf_sts o_sts,
    output cdrb_pkg::t_rsp      o_rsp
);
    import cdrb_pkg::*;

    logic r_vld;
    t_rsp r_rsp;

    // Free when empty or when the held response leaves this cycle
    assign o_sts.valid = r_vld;
    assign o_sts.room  = !r_vld || i_ctl.take;
    assign o_rsp       = r_rsp;

    // Track occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_ctl.load) begin
            r_vld <= 1'b1;
        end else if (i_ctl.take) begin
            r_vld <= 1'b0;
        end
    end

    // Capture the response
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_rsp <= i_rsp;
        end
    end

endmodule

FILE: rtl/coprocessor_dma_register_block.sv
// Top level of the coprocessor DMA register block: request register, core, result register.
// Depends on cdrb_pkg, cdrb_core and cdrb_out_reg.
//
//  Channel  Dir  Bus                          Fields (low bit first)
//  s_axis   in   tdata[31:0], tuser[4:0]      tdata: write_data; tuser: opcode, reg_index
//  m_axis   out  tdata[71:0]                  read_data, beat_valid, beat_local_index,
//                                             beat_dram_index, dma_busy, dma_done,
//                                             interrupt_line, zero padding
//
// One request per cycle while m_axis_tready is high; request register feeds result register.
// Every request yields exactly one response; a tick moves at most one 8-byte beat.
// Synchronous active-low reset leaves the block halted with no transfer pending.
// A stalled result holds in the result register; one more request is taken into the
// request register, after which s_axis_tready drops until the result drains.
module coprocessor_dma_register_block (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [cdrb_pkg::IN_TDATA_W-1:0]   s_axis_tdata,  // write_data
    input  logic [cdrb_pkg::IN_TUSER_W-1:0]   s_axis_tuser,  // opcode, reg_index
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [cdrb_pkg::OUT_TDATA_W-1:0]  m_axis_tdata   // read_data, beat_valid,
                                                             // beat_local_index,
                                                             // beat_dram_index, dma_busy,
                                                             // dma_done, interrupt_line
);
    import cdrb_pkg::*;

    logic      r_in_vld;
    t_req      r_in;
    logic      fire;
    t_rsp      core_rsp;
    t_rsp      out_rsp;
    t_obuf_ctl obuf_ctl;
    t_obuf_sts obuf_sts;

    // Execute when a request is held and the result register has room
    assign fire          = r_in_vld && obuf_sts.room;
    assign s_axis_tready = !r_in_vld || fire;

    // Hold the request register occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_vld <= s_axis_tvalid;
        end
    end

    // Capture the request fields
    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in.opcode     <= s_axis_tuser[1:0];
            r_in.reg_index  <= s_axis_tuser[4:2];
            r_in.write_data <= s_axis_tdata;
        end
    end

    cdrb_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_req   (r_in),
        .o_rsp   (core_rsp)
    );

    assign obuf_ctl.load = fire;
    assign obuf_ctl.take = obuf_sts.valid && m_axis_tready;

    cdrb_out_reg u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (obuf_ctl),
        .i_rsp   (core_rsp),
        .o_sts   (obuf_sts),
        .o_rsp   (out_rsp)
    );

    // Pack the response, first field lowest
    assign m_axis_tvalid = obuf_sts.valid;
    assign m_axis_tdata  = {6'd0,
                            out_rsp.interrupt_line,
                            out_rsp.dma_done,
                            out_rsp.dma_busy,
                            out_rsp.beat_dram_index,
                            out_rsp.beat_local_index,
                            out_rsp.beat_valid,
                            out_rsp.read_data};

endmodule

FILE: rtl/cdrb_checker.sv
// Port-level checker of the coprocessor DMA register block, bound to the top level.
// Depends on cdrb_pkg and coprocessor_dma_register_block_assert.svh.
module cdrb_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              s_axis_tready,
    input logic                              m_axis_tvalid,
    input logic                              m_axis_tready,
    input logic [cdrb_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);
    import cdrb_pkg::*;
    `include "coprocessor_dma_register_block_assert.svh"

    logic        stalled;
    logic        rsp_beat;
    logic        rsp_busy;
    logic        rsp_done;
    logic [29:0] rsp_idx;
    logic [5:0]  rsp_pad;

    // Split the response bus into the fields under check
    assign stalled  = m_axis_tvalid && !m_axis_tready;
    assign rsp_beat = m_axis_tdata[32];
    assign rsp_idx  = m_axis_tdata[62:33];
    assign rsp_busy = m_axis_tdata[63];
    assign rsp_done = m_axis_tdata[64];
    assign rsp_pad  = m_axis_tdata[71:66];

    // Reset empties the result register
    `CDRB_ASSERT_ALWAYS(a_rst_empty, i_clk, !i_rst_n |=> !m_axis_tvalid, "response after reset")

    // Reset empties the request register
    `CDRB_ASSERT_ALWAYS(a_rst_ready, i_clk, !i_rst_n |=> s_axis_tready, "no room after reset")

    // A stalled response stays offered
    `CDRB_ASSERT(a_hold, i_clk, i_rst_n, stalled |=> m_axis_tvalid, "response dropped under stall")

    // A finished transfer is no longer busy
    `CDRB_ASSERT(a_done_idle, i_clk, i_rst_n, m_axis_tvalid && rsp_done |-> !rsp_busy, "done while busy")

    // Beat indexes and padding are zero without a beat
    `CDRB_ASSERT(a_idx_zero, i_clk, i_rst_n, m_axis_tvalid && !rsp_beat |-> rsp_idx == 30'd0 && rsp_pad == 6'd0, "stray beat index")

endmodule

bind coprocessor_dma_register_block cdrb_checker u_cdrb_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
